FILE: sv/pms_pkg.sv
// Shared constants for the periodic message scheduler.
package pms_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int SLOT_W    = 4;
    localparam int ID_W      = 11;
    localparam int PERIOD_W  = 16;
    localparam int STEP_W    = 10;
    localparam int CD_W      = 18;

    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [CD_W:0] CD_MIN = -(19'sd131072);

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = STEP_W'(10);

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE = 2'd1;

endpackage

FILE: sv/periodic_message_scheduler.sv
// Periodic message scheduler: slot table, tick scan sequencer and output register.
//
// Input stream: tuser carries the mode (0 load, 1 tick). A load transaction writes
// one slot (id, period, enable) and clears its countdown in the cycle it is taken.
// A tick transaction, when run enable is set, starts a scan that visits one slot per
// cycle through a single subtract/saturate/add unit while the output does not stall;
// tready stays low through the scan state and the flush state after it, longer while
// the output stalls, and the next transaction is taken once the sequencer is idle.
// Each due slot leaves as one output transaction carrying slot and id; tlast marks
// the last due slot of the tick. A due slot is held one step in a pending register
// until the next due slot (or the end of the scan) decides its tlast.
// When the output side stalls, the scan halts on the next due slot until the output
// register frees up; nothing is dropped. Output tvalid first rises once the second due
// slot, reached in the scan, moves the first into the output register, or once the
// flush does so when only one slot is due.
// Configuration writes (tick step, run enable) take effect at once; issue them idle.
// Reset (synchronous, active low) clears all slot valid bits, the sequencer and the
// output register, and sets tick step to 10 and run enable to 1.
module periodic_message_scheduler
    import pms_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // slot[3:0], frame_id[14:4], period[30:15], enable[31]
    input  logic [S_DATA_W-1:0]   i_s_axis_tdata,
    // mode[0]
    input  logic                  i_s_axis_tuser,

    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // due_slot[3:0], due_id[14:4], zero[15]
    output logic [M_DATA_W-1:0]   o_m_axis_tdata,
    output logic                  o_m_axis_tlast,

    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [STEP_W-1:0]     i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_idx, n_idx;
    logic                     r_pend_v, n_pend_v;
    logic [SLOT_W-1:0]        r_pend_slot, n_pend_slot;
    logic [ID_W-1:0]          r_pend_id, n_pend_id;
    logic                     r_out_v, n_out_v;
    logic [SLOT_W-1:0]        r_out_slot, n_out_slot;
    logic [ID_W-1:0]          r_out_id, n_out_id;
    logic                     r_out_last, n_out_last;

    logic [STEP_W-1:0]        r_tick_step;
    logic                     r_run_enable;

    logic [NUM_SLOTS-1:0]     r_slot_valid;
    logic [ID_W-1:0]          r_slot_id     [NUM_SLOTS];
    logic [PERIOD_W-1:0]      r_slot_period [NUM_SLOTS];
    logic signed [CD_W-1:0]   r_slot_cd     [NUM_SLOTS];

    logic [SLOT_W-1:0]        in_slot;
    logic [ID_W-1:0]          in_id;
    logic [PERIOD_W-1:0]      in_period;
    logic                     in_enable;
    logic                     in_accept;
    logic                     load_wr;
    logic [IDX_W-1:0]         load_idx;

    logic signed [CD_W:0]     cd_diff;
    logic signed [CD_W:0]     cd_sat;
    logic signed [CD_W:0]     cd_sum;
    logic                     cd_due;
    logic signed [CD_W-1:0]   cd_next;
    logic                     out_free;
    logic                     scan_hit;
    logic                     scan_stall;
    logic                     scan_step;
    logic                     scan_end;

    assign in_slot   = i_s_axis_tdata[3:0];
    assign in_id     = i_s_axis_tdata[14:4];
    assign in_period = i_s_axis_tdata[30:15];
    assign in_enable = i_s_axis_tdata[31];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign load_wr         = in_accept && (i_s_axis_tuser == MODE_LOAD)
                             && (int'(in_slot) < NUM_SLOTS);
    assign load_idx        = IDX_W'(in_slot);

    // shared countdown unit: subtract step, saturate, add period back when due
    assign cd_diff = (CD_W+1)'(r_slot_cd[r_idx])
                     - $signed({{(CD_W+1-STEP_W){1'b0}}, r_tick_step});
    assign cd_sat  = (cd_diff < CD_MIN) ? CD_MIN : cd_diff;
    assign cd_due  = (cd_sat <= 0);
    assign cd_sum  = cd_sat + $signed({{(CD_W+1-PERIOD_W){1'b0}}, r_slot_period[r_idx]});
    assign cd_next = cd_due ? cd_sum[CD_W-1:0] : cd_sat[CD_W-1:0];

    assign out_free   = !r_out_v || i_m_axis_tready;
    assign scan_hit   = (r_state == ST_SCAN) && r_slot_valid[r_idx] && cd_due;
    assign scan_stall = scan_hit && r_pend_v && !out_free;
    assign scan_step  = (r_state == ST_SCAN) && !scan_stall;
    assign scan_end   = (r_idx == IDX_W'(NUM_SLOTS - 1));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_pend_id   = r_pend_id;
        n_out_v     = r_out_v && !i_m_axis_tready;
        n_out_slot  = r_out_slot;
        n_out_id    = r_out_id;
        n_out_last  = r_out_last;

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && (i_s_axis_tuser == MODE_TICK) && r_run_enable) begin
                    n_state = ST_SCAN;
                    n_idx   = '0;
                end
            end
            ST_SCAN: begin
                if (scan_step) begin
                    if (scan_hit) begin
                        if (r_pend_v) begin
                            n_out_v    = 1'b1;
                            n_out_slot = r_pend_slot;
                            n_out_id   = r_pend_id;
                            n_out_last = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_slot = SLOT_W'(r_idx);
                        n_pend_id   = r_slot_id[r_idx];
                    end
                    if (scan_end) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_v    = 1'b1;
                    n_out_slot = r_pend_slot;
                    n_out_id   = r_pend_id;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_pend_slot <= n_pend_slot;
        r_pend_id   <= n_pend_id;
        r_out_slot  <= n_out_slot;
        r_out_id    <= n_out_id;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_step  <= TICK_STEP_RESET;
            r_run_enable <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_TICK_STEP:  r_tick_step  <= i_cfg_data;
                CFG_RUN_ENABLE: r_run_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (load_wr) begin
            r_slot_valid[load_idx] <= in_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_wr) begin
            r_slot_id[load_idx]     <= in_id;
            r_slot_period[load_idx] <= in_period;
            r_slot_cd[load_idx]     <= '0;
        end else if (scan_step && r_slot_valid[r_idx]) begin
            r_slot_cd[r_idx] <= cd_next;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {1'b0, r_out_id, r_out_slot};
    assign o_m_axis_tlast  = r_out_last;

    // no pending emission survives outside a tick
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending emission left after tick");

    // an enabled tick starts the scan at slot zero
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_s_axis_tuser == MODE_TICK) && r_run_enable)
        |=> (r_state == ST_SCAN) && (r_idx == '0))
        else $error("tick did not start scan");

    // a load sets the slot's valid bit from its enable
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_wr |=> (r_slot_valid[$past(load_idx)] == $past(in_enable)))
        else $error("load did not update valid bit");

    // the scan never moves on while it holds a due slot it cannot place
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_stall |=> (r_state == ST_SCAN) && $stable(r_idx) && r_pend_v)
        else $error("scan advanced during output stall");

    // the flush leaves the scan only once the pending slot is placed as last
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH && r_pend_v && out_free) |=> r_out_v && r_out_last)
        else $error("final emission of tick not marked last");

endmodule
